// ===== rtl/core/bmhq_pkg.sv =====
package bmhq_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int ID_BITS_DEF  = 10;

  localparam int ID_FIELD_W = 10;
  localparam int KEY_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 11;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    func_t                   func;
    logic [ID_FIELD_W-1:0]   item_id;
    logic signed [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [ID_FIELD_W-1:0]   out_id;
    logic signed [KEY_W-1:0] out_key;
    status_t                 status;
    logic [OCC_W-1:0]        occupancy;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_ROOT,
    S_DN_LAST,
    S_DN_CHK,
    S_DN_LEFT,
    S_DN_RIGHT,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    RD_ROOT,
    RD_LAST,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_ENTRY,
    WR_RDATA,
    WR_WINNER
  } wr_sel_t;

  // Controller to datapath.
  typedef struct packed {
    logic    start_push;
    logic    start_pop;
    logic    set_full;
    logic    set_empty;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    pos_up;
    logic    pos_dn;
    logic    ld_last;
    logic    ld_top;
    logic    ld_child;
    logic    with_right;
    logic    ld_out;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
    logic pos_zero;
    logic up_less;
    logic left_out;
    logic right_in;
    logic dn_stop;
    logic out_free;
  } flags_t;

endpackage

// ===== rtl/core/bmhq_ram.sv =====
module bmhq_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/bmhq_ctrl.sv =====
module bmhq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  bmhq_pkg::flags_t flags,
  output bmhq_pkg::cmd_t   cmd
);

  import bmhq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = !rst_n || (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_ROOT;
    cmd.wr_sel = WR_ENTRY;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!flags.is_pop) begin
            if (flags.full) begin
              cmd.set_full = 1'b1;
              state_nxt    = S_DONE;
            end else begin
              cmd.start_push = 1'b1;
              state_nxt      = S_UP_CHK;
            end
          end else begin
            if (flags.empty) begin
              cmd.set_empty = 1'b1;
              state_nxt     = S_DONE;
            end else begin
              cmd.start_pop = 1'b1;
              cmd.rd_en     = 1'b1;
              cmd.rd_sel    = RD_ROOT;
              state_nxt     = S_DN_ROOT;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (flags.pos_zero) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_ENTRY;
          state_nxt  = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PARENT;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.wr_en = 1'b1;
        if (flags.up_less) begin
          cmd.wr_sel = WR_RDATA;
          cmd.pos_up = 1'b1;
          state_nxt  = S_UP_CHK;
        end else begin
          cmd.wr_sel = WR_ENTRY;
          state_nxt  = S_DONE;
        end
      end
      S_DN_ROOT: begin
        cmd.ld_top = 1'b1;
        if (flags.empty) begin
          state_nxt = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LAST;
          state_nxt  = S_DN_LAST;
        end
      end
      S_DN_LAST: begin
        cmd.ld_last = 1'b1;
        state_nxt   = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (flags.left_out) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_ENTRY;
          state_nxt  = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LEFT;
          state_nxt  = S_DN_LEFT;
        end
      end
      S_DN_LEFT: begin
        if (flags.right_in) begin
          cmd.ld_child = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_RIGHT;
          state_nxt    = S_DN_RIGHT;
        end else begin
          cmd.wr_en = 1'b1;
          if (flags.dn_stop) begin
            cmd.wr_sel = WR_ENTRY;
            state_nxt  = S_DONE;
          end else begin
            cmd.wr_sel = WR_WINNER;
            cmd.pos_dn = 1'b1;
            state_nxt  = S_DN_CHK;
          end
        end
      end
      S_DN_RIGHT: begin
        cmd.with_right = 1'b1;
        cmd.wr_en      = 1'b1;
        if (flags.dn_stop) begin
          cmd.wr_sel = WR_ENTRY;
          state_nxt  = S_DONE;
        end else begin
          cmd.wr_sel = WR_WINNER;
          cmd.pos_dn = 1'b1;
          state_nxt  = S_DN_CHK;
        end
      end
      S_DONE: begin
        if (flags.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/bmhq_dp.sv =====
module bmhq_dp #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = bmhq_pkg::ID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bmhq_pkg::in_word_t  in_word,
  input  bmhq_pkg::cmd_t      cmd,
  output bmhq_pkg::flags_t    flags,
  output logic                out_valid,
  input  logic                out_stall,
  output bmhq_pkg::out_word_t out_word
);

  import bmhq_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = ADDR_W + 2;
  localparam int ENT_W  = ID_BITS + KEY_W;

  logic [ENT_W-1:0]  ent_r, child_r, top_r;
  logic [ADDR_W-1:0] pos_r;
  logic [CNT_W-1:0]  count_r;
  status_t           stat_r;
  logic              out_valid_r;
  out_word_t         out_word_r;

  logic [ENT_W-1:0]  rd_data, wr_data, winner;
  logic [ADDR_W-1:0] rd_addr, parent_idx, pos_m1;
  logic [IDX_W-1:0]  left_idx, right_idx, count_ext, winner_idx;
  logic              win_right;
  logic [ID_BITS+ID_FIELD_W-1:0] in_id_ext, out_id_ext;
  logic [CNT_W+OCC_W-1:0]        occ_ext;

  // Entry layout: identifier above the key.
  function automatic logic signed [KEY_W-1:0] key_of(input logic [ENT_W-1:0] e);
    return $signed(e[KEY_W-1:0]);
  endfunction

  assign pos_m1     = pos_r - ADDR_W'(1);
  assign parent_idx = pos_m1 >> 1;
  assign left_idx   = {1'b0, pos_r, 1'b1};
  assign right_idx  = left_idx + IDX_W'(1);
  assign count_ext  = {{(IDX_W-CNT_W){1'b0}}, count_r};

  assign win_right  = cmd.with_right && (key_of(rd_data) < key_of(child_r));
  assign winner     = cmd.with_right ? (win_right ? rd_data : child_r) : rd_data;
  assign winner_idx = win_right ? right_idx : left_idx;

  assign in_id_ext  = {{ID_BITS{1'b0}}, in_word.item_id};
  assign out_id_ext = {{ID_FIELD_W{1'b0}}, top_r[ENT_W-1:KEY_W]};
  assign occ_ext    = {{OCC_W{1'b0}}, count_r};

  always_comb begin
    case (cmd.rd_sel)
      RD_ROOT:   rd_addr = '0;
      RD_LAST:   rd_addr = count_r[ADDR_W-1:0];
      RD_PARENT: rd_addr = parent_idx;
      RD_LEFT:   rd_addr = left_idx[ADDR_W-1:0];
      RD_RIGHT:  rd_addr = right_idx[ADDR_W-1:0];
      default:   rd_addr = '0;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_ENTRY:  wr_data = ent_r;
      WR_RDATA:  wr_data = rd_data;
      WR_WINNER: wr_data = winner;
      default:   wr_data = ent_r;
    endcase
  end

  bmhq_ram #(
    .WIDTH(ENT_W),
    .DEPTH(CAPACITY)
  ) u_heap_ram (
    .clk    (clk),
    .wr_en  (cmd.wr_en),
    .wr_addr(pos_r),
    .wr_data(wr_data),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    flags.is_pop   = (in_word.func == FUNC_POP);
    flags.full     = (count_r == CNT_W'(CAPACITY));
    flags.empty    = (count_r == '0);
    flags.pos_zero = (pos_r == '0);
    flags.up_less  = key_of(ent_r) < key_of(rd_data);
    flags.left_out = (left_idx >= count_ext);
    flags.right_in = (right_idx < count_ext);
    flags.dn_stop  = key_of(ent_r) <= key_of(winner);
    flags.out_free = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.start_push) begin
      count_r <= count_r + CNT_W'(1);
    end else if (cmd.start_pop) begin
      count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_push) begin
      ent_r <= {in_id_ext[ID_BITS-1:0], in_word.key};
      pos_r <= count_r[ADDR_W-1:0];
    end else if (cmd.ld_last) begin
      ent_r <= rd_data;
      pos_r <= '0;
    end else if (cmd.pos_up) begin
      pos_r <= parent_idx;
    end else if (cmd.pos_dn) begin
      pos_r <= winner_idx[ADDR_W-1:0];
    end
    if (cmd.ld_child) begin
      child_r <= rd_data;
    end
    if (cmd.start_push || cmd.start_pop || cmd.set_full || cmd.set_empty) begin
      top_r <= '0;
    end else if (cmd.ld_top) begin
      top_r <= rd_data;
    end
    if (cmd.set_full) begin
      stat_r <= STAT_FULL;
    end else if (cmd.set_empty) begin
      stat_r <= STAT_EMPTY;
    end else if (cmd.start_push || cmd.start_pop) begin
      stat_r <= STAT_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_word_r.out_id    <= out_id_ext[ID_FIELD_W-1:0];
      out_word_r.out_key   <= key_of(top_r);
      out_word_r.status    <= stat_r;
      out_word_r.occupancy <= occ_ext[OCC_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== rtl/core/binary_min_heap_queue_top.sv =====
// Channel  Direction  Handshake         Word
// in_      input      in_valid/in_stall   func, item_id, key
// out_     output     out_valid/out_stall out_id, out_key, status, occupancy
//
// One word is processed at a time, from the cycle it is accepted through the cycle its
// result is loaded. A push starts the new entry at the bottom and climbs it toward the
// root, one level per parent read; a pop takes the root and, if entries remain, moves
// the last one up and sinks it, reading the left and, where present, the right child at
// each level. The heap memory has a single read port, so each level waits for one or
// two reads. Refused words (push when full, pop when empty) leave the heap untouched.
// Reset is synchronous and active low; it empties the heap at once, with no memory sweep.
// A result waits in an output register while out_stall is high; a new word is accepted
// meanwhile and finishes its heap work, then holds until the register frees.
module binary_min_heap_queue_top #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = bmhq_pkg::ID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bmhq_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output bmhq_pkg::out_word_t out_word
);

  import bmhq_pkg::*;

  // Commands from the controller and flags back from the datapath.
  cmd_t   cmd;
  flags_t flags;

  // The controller sequences a push as a climb and a pop as a sink; the moving
  // entry stays in a register and is written to memory only where it settles.
  bmhq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .flags   (flags),
    .cmd     (cmd)
  );

  // The datapath holds the heap memory, the entry count, the index arithmetic,
  // the key comparators and the output register.
  bmhq_dp #(
    .CAPACITY(CAPACITY),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .flags    (flags),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  // The heap memory is never written while the block is ready for a new word.
  assert property (@(posedge clk) disable iff (!rst_n) !in_stall |-> !cmd.wr_en)
    else $error("heap write while idle");

  // A result is only loaded when the output register is free.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> (!out_valid || !out_stall))
    else $error("result overwrote a waiting word");

  // A refused pop reports an empty heap and no entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == STAT_EMPTY) |->
      (out_word.out_id == '0 && out_word.out_key == '0 && out_word.occupancy == '0))
    else $error("refused pop carries data");

  // A refused push carries no entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == STAT_FULL) |->
      (out_word.out_id == '0 && out_word.out_key == '0))
    else $error("refused push carries data");

endmodule

// ===== tb/sv/bmhq_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the heap queue and keeps its own copy of the heap.
// Each accepted input word is applied to that copy at once; the result word it
// should produce is queued and compared, field by field, with the next result
// word that leaves the block.
module bmhq_checker #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  bmhq_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  logic                out_stall,
  input  bmhq_pkg::out_word_t out_word,
  output int                  fail_count,
  output int                  pending
);

  import bmhq_pkg::*;

  logic [ID_FIELD_W-1:0]   heap_ids  [CAPACITY];
  logic signed [KEY_W-1:0] heap_keys [CAPACITY];
  int unsigned             heap_count;
  out_word_t               due_words [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    heap_count = 0;
  end

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic [ID_FIELD_W-1:0]   t_id;
    logic signed [KEY_W-1:0] t_key;
    t_id         = heap_ids[a];
    t_key        = heap_keys[a];
    heap_ids[a]  = heap_ids[b];
    heap_keys[a] = heap_keys[b];
    heap_ids[b]  = t_id;
    heap_keys[b] = t_key;
  endfunction

  // Applies one operation to the heap copy and returns the result word it yields.
  function automatic out_word_t heap_apply(in_word_t w);
    out_word_t   r;
    int unsigned pos;
    int unsigned up;
    int unsigned child;
    r        = '0;
    r.status = STAT_DONE;
    if (w.func == FUNC_PUSH) begin
      if (heap_count >= CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        pos            = heap_count;
        heap_ids[pos]  = w.item_id;
        heap_keys[pos] = w.key;
        heap_count++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!(heap_keys[pos] < heap_keys[up])) break;
          swap_entries(pos, up);
          pos = up;
        end
      end
    end else if (heap_count == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      r.out_id  = heap_ids[0];
      r.out_key = heap_keys[0];
      heap_count--;
      heap_ids[0]  = heap_ids[heap_count];
      heap_keys[0] = heap_keys[heap_count];
      pos = 0;
      // The right child wins only when strictly smaller; equal keys stop the walk.
      while (2 * pos + 1 < heap_count) begin
        child = 2 * pos + 1;
        if (child + 1 < heap_count && heap_keys[child + 1] < heap_keys[child]) child++;
        if (heap_keys[pos] <= heap_keys[child]) break;
        swap_entries(pos, child);
        pos = child;
      end
    end
    r.occupancy = OCC_W'(heap_count);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_word_t exp_word;
    if (!rst_n) begin
      heap_count = 0;
      due_words.delete();
    end else begin
      if (in_valid && !in_stall) due_words.push_back(heap_apply(in_word));
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          $error("result word with nothing due: out_id %0d out_key %0d status %0d occupancy %0d",
                 out_word.out_id, out_word.out_key, out_word.status, out_word.occupancy);
          fail_count++;
        end else begin
          exp_word = due_words.pop_front();
          if (out_word.out_id !== exp_word.out_id) begin
            $error("out_id: expected %0d, got %0d", exp_word.out_id, out_word.out_id);
            fail_count++;
          end
          if (out_word.out_key !== exp_word.out_key) begin
            $error("out_key: expected %0d, got %0d", exp_word.out_key, out_word.out_key);
            fail_count++;
          end
          if (out_word.status !== exp_word.status) begin
            $error("status: expected %0d, got %0d", exp_word.status, out_word.status);
            fail_count++;
          end
          if (out_word.occupancy !== exp_word.occupancy) begin
            $error("occupancy: expected %0d, got %0d", exp_word.occupancy, out_word.occupancy);
            fail_count++;
          end
        end
      end
    end
    pending <= due_words.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the heap queue. The checker instance beside the block
// does all prediction and comparison; this module only feeds words, paces the
// result side and decides pass or fail at the end.
module tb_top;
  import bmhq_pkg::*;

  localparam int      HEAP_DEPTH   = CAPACITY_DEF;
  localparam int      RANDOM_WORDS = 500;
  // The slowest correct run is roughly 1200 words, each with its sender gap, worst sift
  // and receiver stall, under 0.4 ms; this allows over ten times that.
  localparam longint  RUN_LIMIT_NS = 5_000_000;
  localparam int      TAIL_CYCLES  = 60;

  // How a stretch of random traffic leans between pushes and pops.
  typedef enum int {MIX_EVEN, MIX_FILL, MIX_DRAIN} op_mix_t;
  // How keys are drawn: full 32-bit range, a tight band full of ties, or a middle band.
  typedef enum int {KEYS_FULL, KEYS_TIGHT, KEYS_MID} key_mix_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_word   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_word_t out_word;

  int fail_count;
  int pending;

  // Quiet flags switch off idling on one side for a stretch of traffic.
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int rx_hold  = 0;
  // Entries the heap should hold; used only to steer the final drain.
  int held     = 0;

  always #4 clk = ~clk;

  binary_min_heap_queue_top #(
    .CAPACITY(HEAP_DEPTH),
    .ID_BITS (ID_BITS_DEF)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  bmhq_checker #(
    .CAPACITY(HEAP_DEPTH)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Result side pacing. After each result word is taken, the receiver draws a
  // stall of random length, possibly none, so the stall lands on whatever phase the block is
  // in at that moment: mid-sift, with a finished word waiting, or idle.
  always @(posedge clk) begin : rx_pacing
    int unsigned n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_hold   <= 0;
    end else if (out_valid && !out_stall) begin
      n = rx_quiet ? 0 : $urandom_range(4);
      out_stall <= (n != 0);
      rx_hold   <= (n == 0) ? 0 : n - 1;
    end else if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #RUN_LIMIT_NS;
    $display("CHECK FAILED");
    $finish;
  end

  // Offers one word after a random gap and returns at the edge where it is taken.
  // Valid stays high on return, so back-to-back words need no second assignment
  // in the same time step; anything that waits afterwards must lower it first.
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic push_word(input logic [ID_FIELD_W-1:0] id, input logic signed [KEY_W-1:0] k);
    in_word_t w;
    w.func    = FUNC_PUSH;
    w.item_id = id;
    w.key     = k;
    send_word(w);
    if (held < HEAP_DEPTH) held++;
  endtask

  // The identifier and key of a pop are ignored, but random bits go out anyway.
  task automatic pop_word();
    in_word_t w;
    w.func    = FUNC_POP;
    w.item_id = ID_FIELD_W'($urandom_range(1023));
    w.key     = $urandom;
    send_word(w);
    if (held > 0) held--;
  endtask

  // Stops sending and waits until every predicted result word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic signed [KEY_W-1:0] draw_key(key_mix_t mix);
    case (mix)
      KEYS_TIGHT: draw_key = $signed(32'($urandom_range(8))) - 4;
      KEYS_MID:   draw_key = $signed(32'($urandom_range(65535))) - 32768;
      default:    draw_key = $urandom;
    endcase
  endfunction

  task automatic random_op(op_mix_t mix, key_mix_t keys);
    int unsigned pop_pct;
    case (mix)
      MIX_FILL:  pop_pct = 25;
      MIX_DRAIN: pop_pct = 75;
      default:   pop_pct = 50;
    endcase
    if ($urandom_range(99) < pop_pct) pop_word();
    else push_word(ID_FIELD_W'($urandom_range(1023)), draw_key(keys));
  endtask

  initial begin : stimulus
    int       sent;
    int       seg;
    int       len;
    op_mix_t  mix;
    key_mix_t keys;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: a pop on the empty heap, the key and identifier
    // extremes, repeated keys, then a full drain ending in another empty pop.
    pop_word();
    push_word(10'd0,      32'sd0);
    push_word(10'd1023,   32'sh7FFF_FFFF);
    push_word(10'h2AA,    32'sh8000_0000);
    push_word(10'h155,    -32'sd1);
    push_word(10'd5,      32'sd0);
    push_word(10'd6,      32'sd0);
    push_word(10'd7,      32'sd1);
    push_word(10'd8,      32'sh8000_0000);
    repeat (9) pop_word();
    // Two equal keys under a smaller parent; after one pop the tie must stop the sink.
    push_word(10'd20, 32'sd10);
    push_word(10'd21, 32'sd20);
    push_word(10'd22, 32'sd20);
    repeat (3) pop_word();
    wait_drained();

    // Random stretches, each with its own push/pop balance, key spread and
    // idling. The first stretch always ends with a full drain of the result
    // side before anything else is sent; later ones do so at random.
    sent = 0;
    seg  = 0;
    while (sent < RANDOM_WORDS) begin
      mix      = op_mix_t'($urandom_range(2));
      keys     = key_mix_t'($urandom_range(2));
      len      = $urandom_range(20, 60);
      tx_quiet = ($urandom_range(3) == 0);
      rx_quiet = ($urandom_range(3) == 0);
      repeat (len) begin
        random_op(mix, keys);
        sent++;
      end
      if (seg == 0 || $urandom_range(3) == 0) wait_drained();
      seg++;
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    wait_drained();

    // Empty the heap completely and pop past the bottom.
    while (held > 0) pop_word();
    repeat (2) pop_word();

    // Let every outstanding result word arrive, then leave room for any
    // stray word the block might still produce.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
